// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on every clock edge out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

// ===== hdl/ttrq_pkg.sv =====
// Package: types, constants and codes of the timed task release queue
package ttrq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_DISPATCH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int LIMIT = (MAX_DISPATCH < MAX_RESULTS) ? MAX_DISPATCH : MAX_RESULTS;
	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIMIT + 1);
	localparam int CMDQ_DEPTH = 2;

	localparam logic [1:0] KIND_ENQ = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_NOP = 2'd3;

	localparam logic [2:0] ST_ENQUEUED = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_RELEASED = 3'd2;
	localparam logic [2:0] ST_NONE_DUE = 3'd3;
	localparam logic [2:0] ST_CANCEL_ACK = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [47:0] start_time;
		logic has_repeat;
		logic [47:0] repeat_interval;
		logic has_end;
		logic [47:0] end_time;
		logic [31:0] cancel_id;
		logic [47:0] now;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] task_id;
		logic [47:0] exec_time;
		logic last;
	} res_t;
endpackage

// ===== hdl/ttrq_front.sv =====
// Front end: accepts transactions, drops unused kinds, queues commands
module ttrq_front import ttrq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input cmd_t cmd_in,
	output logic cmd_valid,
	output cmd_t cmd_out,
	input logic cmd_take
);
	`include "assert_macros.svh"

	cmd_t mem_q [CMDQ_DEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic wr_en, rd_en;

	assign full = (cnt_q == 2'(CMDQ_DEPTH));
	// kind 3 has no effect: it is accepted and discarded
	assign wr_en = push && !full && (cmd_in.kind != KIND_NOP);
	assign cmd_valid = (cnt_q != 2'd0);
	assign rd_en = cmd_valid && cmd_take;
	assign cmd_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= 2'(CMDQ_DEPTH), "command queue overflow")
	`ASSERT_IMPLY(a_no_wr_full, clk, arst_n, full, !wr_en, "write while full")
	`ASSERT_IMPLY(a_take_valid, clk, arst_n, rd_en, cmd_valid, "read of empty command queue")
endmodule

// ===== hdl/ttrq_back.sv =====
// Back end: entry table, sequential scan, release and result register
module ttrq_back import ttrq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_take,
	output logic empty,
	input logic pop,
	output res_t res
);
	`include "assert_macros.svh"

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_ACT = 5'b00100,
		S_EMIT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic [QUEUE_DEPTH-1:0] valid_q, canc_q;
	logic [31:0] id_q [QUEUE_DEPTH];
	logic [47:0] time_q [QUEUE_DEPTH];
	logic [48:0] rep_q [QUEUE_DEPTH];
	logic [48:0] end_q [QUEUE_DEPTH];
	logic [31:0] next_id_q;
	logic [47:0] now_q;
	logic [SLOT_W-1:0] idx_q;
	logic best_ok_q;
	logic [SLOT_W-1:0] best_q;
	logic [47:0] best_time_q;
	logic [31:0] best_id_q;
	logic [CNT_W-1:0] count_q;
	logic res_valid_q;
	res_t res_q;
	// result waiting to be published; a release is held until the next scan shows
	// whether it is the last one of the tick
	res_t hold_q;
	logic hold_ok_q;
	logic res_load;
	logic [48:0] nxt_q;
	logic [SLOT_W-1:0] cur;
	logic better, free_ok;
	logic [SLOT_W-1:0] free_slot;

	assign empty = !res_valid_q;
	assign res = res_q;
	assign cmd_take = (state_q == S_IDLE) && cmd_valid;
	assign cur = idx_q;
	assign res_load = ((state_q == S_EMIT) && hold_ok_q) ||
		((state_q == S_DONE) && (!res_valid_q || pop));

	always_comb begin
		free_ok = 1'b0;
		free_slot = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign better = valid_q[cur] && (time_q[cur] < now_q) && (!best_ok_q ||
		(time_q[cur] < best_time_q) ||
		((time_q[cur] == best_time_q) && (id_q[cur] < best_id_q)));

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.kind == KIND_ENQ && free_ok) begin
					id_q[free_slot] <= next_id_q;
					time_q[free_slot] <= cmd.start_time;
					rep_q[free_slot] <= cmd.has_repeat ? {1'b1, cmd.repeat_interval} : '0;
					end_q[free_slot] <= (cmd.has_repeat && cmd.has_end) ?
						{1'b1, cmd.end_time} : '0;
				end
			end
			S_EMIT: begin
				if (!nxt_q[48]) time_q[best_q] <= nxt_q[47:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			canc_q <= '0;
			next_id_q <= '0;
			res_valid_q <= 1'b0;
			idx_q <= '0;
			best_ok_q <= 1'b0;
			count_q <= '0;
			hold_ok_q <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (pop) res_valid_q <= 1'b0;
			if (res_load)
				res_q <= '{status: hold_q.status, task_id: hold_q.task_id,
					exec_time: hold_q.exec_time, last: hold_q.last || (state_q == S_DONE)};
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							KIND_ENQ: begin
								hold_q <= '{status: free_ok ? ST_ENQUEUED : ST_FULL,
									task_id: free_ok ? next_id_q : 32'd0,
									exec_time: 48'd0, last: 1'b1};
								if (free_ok) begin
									valid_q[free_slot] <= 1'b1;
									canc_q[free_slot] <= 1'b0;
									next_id_q <= next_id_q + 32'd1;
								end
								state_q <= S_DONE;
							end
							KIND_CANCEL: begin
								for (int i = 0; i < QUEUE_DEPTH; i++)
									if (valid_q[i] && id_q[i] == cmd.cancel_id)
										canc_q[i] <= 1'b1;
								hold_q <= '{status: ST_CANCEL_ACK, task_id: cmd.cancel_id,
									exec_time: 48'd0, last: 1'b1};
								state_q <= S_DONE;
							end
							default: begin
								now_q <= cmd.now;
								count_q <= '0;
								idx_q <= '0;
								best_ok_q <= 1'b0;
								hold_ok_q <= 1'b0;
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					// one entry per cycle, keeping the earliest due so far
					if (better) begin
						best_ok_q <= 1'b1;
						best_q <= cur;
						best_time_q <= time_q[cur];
						best_id_q <= id_q[cur];
					end
					if (idx_q == SLOT_W'(QUEUE_DEPTH - 1)) state_q <= S_ACT;
					else idx_q <= idx_q + 1'b1;
				end
				S_ACT: begin
					idx_q <= '0;
					nxt_q <= {1'b0, best_time_q} + {1'b0, rep_q[best_q][47:0]};
					if (!best_ok_q) begin
						if (!hold_ok_q)
							hold_q <= '{status: ST_NONE_DUE, task_id: 32'd0,
								exec_time: 48'd0, last: 1'b1};
						state_q <= S_DONE;
					end else if (canc_q[best_q]) begin
						valid_q[best_q] <= 1'b0;
						canc_q[best_q] <= 1'b0;
						best_ok_q <= 1'b0;
						state_q <= S_SCAN;
					end else if (!hold_ok_q || !res_valid_q || pop) begin
						best_ok_q <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// the held release goes out with last clear, this one takes its place
					count_q <= count_q + 1'b1;
					hold_ok_q <= 1'b1;
					hold_q <= '{status: ST_RELEASED, task_id: best_id_q,
						exec_time: best_time_q, last: 1'b0};
					if (!rep_q[best_q][48] || nxt_q[48] ||
						(end_q[best_q][48] && nxt_q[47:0] >= end_q[best_q][47:0]))
						valid_q[best_q] <= 1'b0;
					if (count_q == CNT_W'(LIMIT - 1)) state_q <= S_DONE;
					else state_q <= S_SCAN;
				end
				S_DONE: begin
					if (!res_valid_q || pop) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLY(a_emit_room, clk, arst_n, state_q == S_EMIT && hold_ok_q, !res_valid_q, "release over an unread result")
	`ASSERT_IMPLY(a_count_lim, clk, arst_n, state_q == S_SCAN, count_q < CNT_W'(LIMIT), "release limit exceeded")
	`ASSERT_ALWAYS(a_canc_valid, clk, arst_n, (canc_q & ~valid_q) == '0, "cancel mark on a free entry")
endmodule

// ===== hdl/timed_task_release_queue.sv =====
// Timed task release queue: one command at a time through a slot-by-slot scan.
// Enqueue and cancel: result held on accept, loaded once the output register is free.
// Tick: one scan per release, one more per cancelled entry dropped, and a final scan
// unless the release limit ends it; a release waits for a later scan or the limit.
// Input side buffers two commands; results wait in one output register.
// Asynchronous active-low reset empties the table and restarts ids at zero.
module timed_task_release_queue import ttrq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] kind,
	input logic [47:0] start_time,
	input logic has_repeat,
	input logic [47:0] repeat_interval,
	input logic has_end,
	input logic [47:0] end_time,
	input logic [31:0] cancel_id,
	input logic [47:0] now,
	output logic empty,
	input logic pop,
	output logic [2:0] status,
	output logic [31:0] task_id,
	output logic [47:0] exec_time,
	output logic last
);
	cmd_t cmd_in, cmd;
	logic cmd_valid, cmd_take;
	res_t res;

	assign cmd_in = '{kind: kind, start_time: start_time, has_repeat: has_repeat,
		repeat_interval: repeat_interval, has_end: has_end, end_time: end_time,
		cancel_id: cancel_id, now: now};

	ttrq_front u_front (.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.cmd_in(cmd_in), .cmd_valid(cmd_valid), .cmd_out(cmd), .cmd_take(cmd_take));

	ttrq_back u_back (.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .empty(empty), .pop(pop), .res(res));

	assign status = res.status;
	assign task_id = res.task_id;
	assign exec_time = res.exec_time;
	assign last = res.last;
endmodule
